// ===== rtl/linear_tween_slot_scheduler_unit_assert.svh =====
// assertion macros used by the checker file ltss_check.sv
`ifndef LINEAR_TWEEN_SLOT_SCHEDULER_UNIT_ASSERT_SVH
`define LINEAR_TWEEN_SLOT_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication
`define LTSS_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("ltss check failed");

// next-cycle implication
`define LTSS_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ltss check failed");

`endif

// ===== rtl/ltss_pkg.sv =====
`timescale 1ns / 1ps

package ltss_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SLOT_W     = 4;
  localparam int VAL_W      = 16;
  localparam int SPAN_W     = 16;
  localparam int CLK_W      = 32;
  localparam int PROD_W     = 2 * SPAN_W;
  localparam int DIV_STEPS  = SPAN_W;
  localparam int CNT_W      = $clog2(DIV_STEPS + 1);

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_LOAD,
    ST_MUL,
    ST_DIVGO,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic idx_clr;
    logic idx_inc;
    logic load;
    logic mul;
    logic div_start;
    logic emit_start;
    logic emit_tick;
  } cmd_t;

  typedef struct packed {
    logic cur_active;
    logic idx_last;
    logic fin;
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/linear_tween_slot_scheduler_unit.sv =====
`timescale 1ns / 1ps
// start word: reply loaded in START once output is free; next word taken as it goes valid
// tick word: SCAN skips idle slots; a finishing slot goes LOAD, MUL, EMIT; one still moving
//   goes LOAD, MUL, DIVGO, DIV (16-step restoring divider), EMIT; EMIT waits on the sink
// a tick scans all 16 slots; one word in flight at a time
// the output register frees the scan from a slow sink
// reset (sync, active high) clears the clock, all slot busy bits, the fsm and out_valid

module linear_tween_slot_scheduler_unit (
  input  logic                               clk,
  input  logic                               rst,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               kind,
  input  logic signed [ltss_pkg::VAL_W-1:0]  begin_value,
  input  logic signed [ltss_pkg::VAL_W-1:0]  end_value,
  input  logic [ltss_pkg::SPAN_W-1:0]        span_ms,
  input  logic [ltss_pkg::SPAN_W-1:0]        step_ms,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               is_start_reply,
  output logic                               accepted,
  output logic [ltss_pkg::SLOT_W-1:0]        slot,
  output logic signed [ltss_pkg::VAL_W-1:0]  value,
  output logic                               finished,
  output logic                               last
);

  // commands from the fsm, status back from the datapath
  ltss_pkg::cmd_t  cmd;
  ltss_pkg::stat_t stat;

  // sequencer: start reply, or a scan over the slots with load / multiply /
  // divide / emit for every moving slot and load / emit for one that finishes
  ltss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // slot store, ms clock, multiplier, divider and output register
  ltss_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .kind           (kind),
    .begin_value    (begin_value),
    .end_value      (end_value),
    .span_ms        (span_ms),
    .step_ms        (step_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .is_start_reply (is_start_reply),
    .accepted       (accepted),
    .slot           (slot),
    .value          (value),
    .finished       (finished),
    .last           (last)
  );

endmodule

// ===== rtl/ltss_div.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
// the dividend is known to be below divisor << SPAN_W, so the quotient fits SPAN_W bits
module ltss_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ltss_pkg::PROD_W-1:0]     dividend,
  input  logic [ltss_pkg::SPAN_W-1:0]     divisor,
  output logic                            busy,
  output logic [ltss_pkg::SPAN_W-1:0]     quotient
);

  logic [ltss_pkg::SPAN_W-1:0] rem;
  logic [ltss_pkg::SPAN_W-1:0] quo;
  logic [ltss_pkg::CNT_W-1:0]  cnt;
  logic [ltss_pkg::SPAN_W+1:0] trial;
  logic                        ge;

  assign trial = {1'b0, rem, quo[ltss_pkg::SPAN_W-1]} - {2'b00, divisor};
  assign ge    = ~trial[ltss_pkg::SPAN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= ltss_pkg::CNT_W'(ltss_pkg::DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == ltss_pkg::CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[ltss_pkg::PROD_W-1:ltss_pkg::SPAN_W];
      quo <= dividend[ltss_pkg::SPAN_W-1:0];
    end else if (busy) begin
      rem <= ge ? trial[ltss_pkg::SPAN_W-1:0] : {rem[ltss_pkg::SPAN_W-2:0], quo[ltss_pkg::SPAN_W-1]};
      quo <= {quo[ltss_pkg::SPAN_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/ltss_ctrl.sv =====
`timescale 1ns / 1ps

module ltss_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            kind,
  input  ltss_pkg::stat_t stat,
  output logic            in_ready,
  output ltss_pkg::cmd_t  cmd
);

  ltss_pkg::state_t state;
  ltss_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ltss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ltss_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next  = (kind == ltss_pkg::KIND_TICK) ? ltss_pkg::ST_SCAN : ltss_pkg::ST_START;
        end
      end
      ltss_pkg::ST_START: begin
        if (stat.out_free) begin
          cmd.emit_start = 1'b1;
          state_next     = ltss_pkg::ST_IDLE;
        end
      end
      ltss_pkg::ST_SCAN: begin
        if (stat.cur_active) begin
          state_next = ltss_pkg::ST_LOAD;
        end else if (stat.idx_last) begin
          state_next = ltss_pkg::ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ltss_pkg::ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ltss_pkg::ST_MUL;
      end
      ltss_pkg::ST_MUL: begin
        if (stat.fin) begin
          state_next = ltss_pkg::ST_EMIT;
        end else begin
          cmd.mul    = 1'b1;
          state_next = ltss_pkg::ST_DIVGO;
        end
      end
      ltss_pkg::ST_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next    = ltss_pkg::ST_DIV;
      end
      ltss_pkg::ST_DIV: begin
        if (!stat.div_busy) begin
          state_next = ltss_pkg::ST_EMIT;
        end
      end
      ltss_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_tick = 1'b1;
          if (stat.idx_last) begin
            state_next = ltss_pkg::ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = ltss_pkg::ST_SCAN;
          end
        end
      end
      default: begin
        state_next = ltss_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ltss_dp.sv =====
`timescale 1ns / 1ps

module ltss_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  ltss_pkg::cmd_t                     cmd,
  output ltss_pkg::stat_t                    stat,
  input  logic                               kind,
  input  logic signed [ltss_pkg::VAL_W-1:0]  begin_value,
  input  logic signed [ltss_pkg::VAL_W-1:0]  end_value,
  input  logic [ltss_pkg::SPAN_W-1:0]        span_ms,
  input  logic [ltss_pkg::SPAN_W-1:0]        step_ms,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               is_start_reply,
  output logic                               accepted,
  output logic [ltss_pkg::SLOT_W-1:0]        slot,
  output logic signed [ltss_pkg::VAL_W-1:0]  value,
  output logic                               finished,
  output logic                               last
);

  localparam int N = ltss_pkg::SLOT_COUNT;
  localparam int W = ltss_pkg::VAL_W;
  localparam int S = ltss_pkg::SPAN_W;

  logic [ltss_pkg::CLK_W-1:0] clock_ms;
  logic [N-1:0]               slot_active;
  logic [W-1:0]               slot_begin [N];
  logic [W-1:0]               slot_end [N];
  logic [S-1:0]               slot_span [N];
  logic [ltss_pkg::CLK_W-1:0] slot_origin_ms [N];

  logic [W-1:0]               lat_begin;
  logic [W-1:0]               lat_end;
  logic [S-1:0]               lat_span;

  logic [ltss_pkg::IDX_W-1:0] idx;
  logic                       fin;
  logic [S-1:0]               elapsed;
  logic [S-1:0]               diff_mag;
  logic                       diff_neg;
  logic [ltss_pkg::PROD_W-1:0] prod;

  logic                       free_found;
  logic [ltss_pkg::IDX_W-1:0] free_idx;
  logic                       above_any;
  logic [ltss_pkg::CLK_W-1:0] el_full;
  logic                       fin_c;
  logic [W:0]                 diff_c;
  logic [W:0]                 mag_c;
  logic [ltss_pkg::PROD_W-1:0] prod_c;
  logic                       div_busy;
  logic [S-1:0]               quo;
  logic [W+1:0]               sum_c;
  logic [W-1:0]               tick_val;
  logic                       out_free;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!slot_active[i]) begin
        free_found = 1'b1;
        free_idx   = ltss_pkg::IDX_W'(i);
      end
    end
  end

  // any active slot after the current one
  always_comb begin
    above_any = 1'b0;
    for (int i = 0; i < N; i++) begin
      if ((ltss_pkg::IDX_W+1)'(i) > {1'b0, idx} && slot_active[i]) begin
        above_any = 1'b1;
      end
    end
  end

  assign el_full = clock_ms - slot_origin_ms[idx];
  assign fin_c   = (slot_span[idx] == '0) ||
                   (el_full >= {{(ltss_pkg::CLK_W-S){1'b0}}, slot_span[idx]});
  assign diff_c  = {slot_end[idx][W-1], slot_end[idx]} - {slot_begin[idx][W-1], slot_begin[idx]};
  assign mag_c   = diff_c[W] ? (~diff_c + 1'b1) : diff_c;
  assign prod_c  = ltss_pkg::PROD_W'(diff_mag) * ltss_pkg::PROD_W'(elapsed);

  assign sum_c    = {{2{slot_begin[idx][W-1]}}, slot_begin[idx]} +
                    (diff_neg ? (~{2'b00, quo} + 1'b1) : {2'b00, quo});
  assign tick_val = fin ? slot_end[idx] : sum_c[W-1:0];

  assign out_free = !out_valid || out_ready;

  ltss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (slot_span[idx]),
    .busy     (div_busy),
    .quotient (quo)
  );

  assign stat.cur_active = slot_active[idx];
  assign stat.idx_last   = (idx == ltss_pkg::IDX_W'(N - 1));
  assign stat.fin        = fin;
  assign stat.div_busy   = div_busy;
  assign stat.out_free   = out_free;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_ms    <= '0;
      slot_active <= '0;
      idx         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.capture && kind == ltss_pkg::KIND_TICK) begin
        clock_ms <= clock_ms + ltss_pkg::CLK_W'(step_ms);
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.emit_start && free_found) begin
        slot_active[free_idx] <= 1'b1;
      end else if (cmd.emit_tick && fin) begin
        slot_active[idx] <= 1'b0;
      end
      if (cmd.emit_start || cmd.emit_tick) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lat_begin <= begin_value;
      lat_end   <= end_value;
      lat_span  <= span_ms;
    end
    if (cmd.emit_start && free_found) begin
      slot_begin[free_idx]     <= lat_begin;
      slot_end[free_idx]       <= lat_end;
      slot_span[free_idx]      <= lat_span;
      slot_origin_ms[free_idx] <= clock_ms;
    end
    if (cmd.load) begin
      fin      <= fin_c;
      elapsed  <= el_full[S-1:0];
      diff_mag <= mag_c[W-1:0];
      diff_neg <= diff_c[W];
    end
    if (cmd.mul) begin
      prod <= prod_c;
    end
    if (cmd.emit_start) begin
      is_start_reply <= 1'b1;
      accepted       <= free_found;
      slot           <= free_found ? ltss_pkg::SLOT_W'(free_idx) : '0;
      value          <= free_found ? lat_begin : '0;
      finished       <= 1'b0;
      last           <= 1'b1;
    end else if (cmd.emit_tick) begin
      is_start_reply <= 1'b0;
      accepted       <= 1'b1;
      slot           <= ltss_pkg::SLOT_W'(idx);
      value          <= tick_val;
      finished       <= fin;
      last           <= !above_any;
    end
  end

endmodule

// ===== rtl/ltss_check.sv =====
`timescale 1ns / 1ps
`include "linear_tween_slot_scheduler_unit_assert.svh"

module ltss_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        is_start_reply,
  input logic                        accepted,
  input logic [ltss_pkg::SLOT_W-1:0] slot,
  input logic [ltss_pkg::VAL_W-1:0]  value,
  input logic                        finished,
  input logic                        last
);

  // stalled result word holds
  `LTSS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(value) && $stable(slot) && $stable(last) && $stable(finished) && $stable(accepted) && $stable(is_start_reply))

  // a tick still in progress takes no new word
  `LTSS_ASSERT_IMP(a_busy_mid_tick, clk, rst, out_valid && !last, !in_ready)

  // a taken word keeps the block busy next cycle
  `LTSS_ASSERT_NXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready)

endmodule

bind linear_tween_slot_scheduler_unit ltss_check u_check (.*);
